// ===== hw/rtl/lrgp_pkg.sv =====
`default_nettype none
package lrgp_pkg;

  localparam int unsigned MaxRod   = 64;
  localparam int unsigned HistAw   = $clog2(MaxRod);
  localparam int unsigned MaxSites = 4096;
  localparam int unsigned SiteW    = $clog2(MaxSites) + 1;
  localparam int unsigned DensW    = 17;
  localparam int unsigned LenW     = 7;
  localparam int unsigned N0W      = DensW + HistAw;
  localparam int unsigned TotW     = 48;
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned MuW      = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam logic [MulW-1:0] Ln2Q30 = 33'd744261118;
  localparam int unsigned OneQ16   = 65536;
  localparam int unsigned LogIters = 20;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROD_LENGTH     = 2'd0,
    REG_WALL_POS       = 2'd1,
    REG_LATTICE_LENGTH = 2'd2,
    REG_CHEM_POTENTIAL = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JOB_Y1  = 2'd0,
    JOB_Y0  = 2'd1,
    JOB_RHO = 2'd2
  } job_e;

  typedef struct packed {
    logic              clr;
    logic              we;
    logic [HistAw-1:0] waddr;
    logic [DensW-1:0]  wdata;
    logic [HistAw-1:0] raddr;
  } hist_req_t;

  // Shift right with rounding half away from zero.
  function automatic logic signed [ProdW-1:0] rnd_shift(input logic signed [ProdW-1:0] v,
                                                         input int unsigned s);
    logic [ProdW-1:0] mag;
    mag = v[ProdW-1] ? (~v + 64'd1) : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return v[ProdW-1] ? $signed(~mag + 64'd1) : $signed(mag);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lrgp_if.sv =====
`default_nettype none
interface lrgp_in_if;
  import lrgp_pkg::*;
  logic             valid;
  logic             ready;
  logic [DensW-1:0] density;
  logic             last;
  modport source (output valid, density, last, input ready);
  modport sink (input valid, density, last, output ready);
endinterface

interface lrgp_out_if;
  import lrgp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [TotW-1:0] grand_potential;
  logic                   saturated;
  modport source (output valid, grand_potential, saturated, input ready);
  modport sink (input valid, grand_potential, saturated, output ready);
endinterface

interface lrgp_cfg_if;
  import lrgp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [MuW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lrgp_hist.sv =====
`default_nettype none
module lrgp_hist (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  lrgp_pkg::hist_req_t       req_i,
  output logic [lrgp_pkg::DensW-1:0] rdata_o
);
  import lrgp_pkg::*;

  logic [DensW-1:0]  mem [MaxRod];
  logic [MaxRod-1:0] vld_q;
  logic [DensW-1:0]  rd_q;
  logic              rd_vld_q;

  // Entries that were not written since the last clear read as zero density.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[req_i.raddr];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[req_i.raddr];
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/lrgp_mul.sv =====
`default_nettype none
module lrgp_mul (
  input  wire                               clk_i,
  input  wire signed [lrgp_pkg::MulW-1:0]   a_i,
  input  wire signed [lrgp_pkg::MulW-1:0]   b_i,
  output logic signed [lrgp_pkg::ProdW-1:0] p_o
);
  import lrgp_pkg::*;

  logic signed [2*MulW-1:0] full;

  assign full = (2*MulW)'(a_i) * (2*MulW)'(b_i);

  always_ff @(posedge clk_i) begin
    p_o <= full[ProdW-1:0];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lattice_rod_grand_potential_sum.sv =====
// Lattice rod grand potential sum.
// Density samples (unsigned Q1.16) arrive one beat at a time on in_i; the beat
// with last set closes a profile and produces one beat on out_o carrying the
// accumulated sum in signed Q31.16 and a flag that tells whether the total
// clipped at the 48-bit limits. Other samples produce no output beat.
// Registers are written on cfg_i (index 0 rod length, 1 wall position,
// 2 lattice length, 3 chemical potential); the port always takes a beat and
// should only be used while no sample is in flight.
// Each sample is processed by a small sequencer around one shared registered
// multiplier: the window sum reads the history memory once for each of the
// rod length minus one preceding sites, then up to three natural logarithms
// are taken (a normalizing step, twenty squaring steps and a scaling by
// ln 2), and each logarithm is followed by a product. A sample with zero
// density skips the third logarithm and the products after it, and a sample
// outside the summed range goes straight to accumulation. in_i is not ready
// while a sample is being worked on or while the result beat waits for the
// receiver; a stalled receiver simply holds the block in that wait. Reset
// clears the registers to their defaults and empties the profile state at
// once.
`default_nettype none
module lattice_rod_grand_potential_sum (
  input  wire        clk_i,
  input  wire        rst_ni,
  lrgp_cfg_if.sink   cfg_i,
  lrgp_in_if.sink    in_i,
  lrgp_out_if.source out_o
);
  import lrgp_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'h0001,
    ST_SUM  = 13'h0002,
    ST_LOGI = 13'h0004,
    ST_SQ   = 13'h0008,
    ST_SQW  = 13'h0010,
    ST_LNM  = 13'h0020,
    ST_LNW  = 13'h0040,
    ST_PM   = 13'h0080,
    ST_PW   = 13'h0100,
    ST_MU   = 13'h0200,
    ST_MUW  = 13'h0400,
    ST_ACC  = 13'h0800,
    ST_OUT  = 13'h1000
  } state_e;

  // Configuration registers.
  logic [LenW-1:0]       rod_q;
  logic [11:0]           wall_q;
  logic [12:0]           llen_q;
  logic signed [MuW-1:0] mu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rod_q  <= 7'd2;
      wall_q <= '0;
      llen_q <= 13'd4096;
      mu_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ROD_LENGTH:     rod_q  <= cfg_i.data[LenW-1:0];
        REG_WALL_POS:       wall_q <= cfg_i.data[11:0];
        REG_LATTICE_LENGTH: llen_q <= cfg_i.data[12:0];
        REG_CHEM_POTENTIAL: mu_q   <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  state_e                  state_q, state_d;
  logic [DensW-1:0]        rho_q, rho_d;
  logic                    last_q, last_d;
  logic [LenW-1:0]         len_q, len_d;
  logic                    rng_q, rng_d;
  logic [LenW-1:0]         cnt_q, cnt_d;
  logic                    pend_q, pend_d;
  logic [N0W-1:0]          n0_q, n0_d;
  logic [DensW-1:0]        y1_q, y1_d, y0_q, y0_d;
  logic [15:0]             x1_q, x1_d, x0_q, x0_d;
  job_e                    job_q, job_d;
  logic [4:0]              e_q, e_d;
  logic [30:0]             m_q, m_d;
  logic [LogIters-1:0]     frac_q, frac_d;
  logic [4:0]              it_q, it_d;
  logic signed [23:0]      ln_q, ln_d;
  logic signed [33:0]      c_q, c_d;
  logic signed [TotW-1:0]  tot_q, tot_d;
  logic                    clip_q, clip_d;
  logic [HistAw-1:0]       wr_q, wr_d;
  logic [SiteW-1:0]        site_q, site_d;
  logic signed [TotW-1:0]  gp_q, gp_d;
  logic                    sat_q, sat_d;

  // Combinational helpers.
  logic [LenW-1:0]         len_c;
  logic signed [14:0]      end_c;
  logic                    in_rng_c;
  logic                    issue_c;
  logic [N0W:0]            n1_c;
  logic [15:0]             x1_c, x0_c;
  logic [DensW-1:0]        opnd_c;
  logic [4:0]              msb_c;
  logic [31:0]             sq_c;
  logic signed [24:0]      l2_c;
  logic signed [33:0]      r_c;
  logic signed [TotW:0]    sum_c;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic [DensW-1:0]        hist_rd;
  hist_req_t               hreq;

  lrgp_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rdata_o(hist_rd)
  );

  lrgp_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign len_c = (rod_q == '0) ? 7'd1 : ((rod_q > LenW'(MaxRod)) ? LenW'(MaxRod) : rod_q);
  assign end_c = $signed({2'b0, llen_q}) - $signed({3'b0, wall_q})
               - $signed({8'b0, len_c}) + 15'sd3;
  assign in_rng_c = (site_q < SiteW'(MaxSites)) && (site_q >= {1'b0, wall_q})
                  && ($signed({2'b0, site_q}) < end_c);

  // Window sums are clamped just below one before the psi terms.
  assign n1_c = {1'b0, n0_q} + (N0W + 1)'(rho_q);
  assign x1_c = (|n1_c[N0W:16]) ? 16'hFFFF : n1_c[15:0];
  assign x0_c = (|n0_q[N0W-1:16]) ? 16'hFFFF : n0_q[15:0];

  assign issue_c = cnt_q < len_q;

  always_comb begin
    unique case (job_q)
      JOB_Y1:  opnd_c = y1_q;
      JOB_Y0:  opnd_c = y0_q;
      default: opnd_c = rho_q;
    endcase
  end

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < DensW; i++) begin
      if (opnd_c[i]) msb_c = 5'(i);
    end
  end

  assign sq_c  = prod[61:30];
  assign l2_c  = $signed({e_q - 5'd16, frac_q});
  assign r_c   = 34'(rnd_shift(prod, 16));
  assign sum_c = (TotW + 1)'(tot_q) + (TotW + 1)'(c_q);

  always_comb begin
    state_d = state_q;
    rho_d   = rho_q;
    last_d  = last_q;
    len_d   = len_q;
    rng_d   = rng_q;
    cnt_d   = cnt_q;
    pend_d  = 1'b0;
    n0_d    = n0_q;
    y1_d    = y1_q;
    y0_d    = y0_q;
    x1_d    = x1_q;
    x0_d    = x0_q;
    job_d   = job_q;
    e_d     = e_q;
    m_d     = m_q;
    frac_d  = frac_q;
    it_d    = it_q;
    ln_d    = ln_q;
    c_d     = c_q;
    tot_d   = tot_q;
    clip_d  = clip_q;
    wr_d    = wr_q;
    site_d  = site_q;
    gp_d    = gp_q;
    sat_d   = sat_q;
    mul_a   = '0;
    mul_b   = '0;
    hreq    = '0;
    hreq.raddr = wr_q - cnt_q[HistAw-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rho_d  = in_i.density;
          last_d = in_i.last;
          len_d  = len_c;
          rng_d  = in_rng_c;
          cnt_d  = 7'd1;
          n0_d   = '0;
          state_d = in_rng_c ? ST_SUM : ST_ACC;
        end
      end
      ST_SUM: begin
        // Reads are pipelined: one issued per cycle, its data added in the next cycle.
        if (issue_c) begin
          cnt_d  = cnt_q + 7'd1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          n0_d = n0_q + N0W'(hist_rd);
        end
        if (!issue_c && !pend_q) begin
          x1_d  = x1_c;
          x0_d  = x0_c;
          y1_d  = DensW'(OneQ16) - {1'b0, x1_c};
          y0_d  = DensW'(OneQ16) - {1'b0, x0_c};
          job_d = JOB_Y1;
          state_d = ST_LOGI;
        end
      end
      ST_LOGI: begin
        e_d    = msb_c;
        m_d    = {14'b0, opnd_c} << (5'd30 - msb_c);
        frac_d = '0;
        it_d   = '0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        mul_a = {2'b0, m_q};
        mul_b = {2'b0, m_q};
        state_d = ST_SQW;
      end
      ST_SQW: begin
        m_d    = sq_c[31] ? sq_c[31:1] : sq_c[30:0];
        frac_d = {frac_q[LogIters-2:0], sq_c[31]};
        it_d   = it_q + 5'd1;
        state_d = (it_q == 5'(LogIters - 1)) ? ST_LNM : ST_SQ;
      end
      ST_LNM: begin
        mul_a = MulW'(l2_c);
        mul_b = Ln2Q30;
        state_d = ST_LNW;
      end
      ST_LNW: begin
        ln_d = 24'(rnd_shift(prod, 34));
        state_d = ST_PM;
      end
      ST_PM: begin
        unique case (job_q)
          JOB_Y1: begin
            mul_a = MulW'(ln_q);
            mul_b = {16'b0, y1_q};
          end
          JOB_Y0: begin
            mul_a = MulW'(ln_q);
            mul_b = {16'b0, y0_q};
          end
          default: begin
            mul_a = MulW'(ln_q) - 33'sd65536;
            mul_b = {16'b0, rho_q};
          end
        endcase
        state_d = ST_PW;
      end
      ST_PW: begin
        unique case (job_q)
          JOB_Y1: begin
            c_d   = $signed({18'b0, x1_q}) + r_c;
            job_d = JOB_Y0;
            state_d = ST_LOGI;
          end
          JOB_Y0: begin
            c_d   = c_q - $signed({18'b0, x0_q}) - r_c;
            job_d = JOB_RHO;
            state_d = (rho_q != '0) ? ST_LOGI : ST_ACC;
          end
          default: begin
            c_d = c_q + r_c;
            state_d = ST_MU;
          end
        endcase
      end
      ST_MU: begin
        mul_a = MulW'(mu_q);
        mul_b = {16'b0, rho_q};
        state_d = ST_MUW;
      end
      ST_MUW: begin
        c_d = c_q - r_c;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (rng_q) begin
          if (sum_c[TotW] != sum_c[TotW-1]) begin
            tot_d  = sum_c[TotW] ? {1'b1, {(TotW-1){1'b0}}} : {1'b0, {(TotW-1){1'b1}}};
            clip_d = 1'b1;
          end else begin
            tot_d = sum_c[TotW-1:0];
          end
        end
        hreq.we    = 1'b1;
        hreq.waddr = wr_q;
        hreq.wdata = rho_q;
        wr_d = wr_q + HistAw'(1);
        if (site_q < SiteW'(MaxSites)) begin
          site_d = site_q + SiteW'(1);
        end
        if (last_q) begin
          gp_d   = tot_d;
          sat_d  = clip_d;
          hreq.clr = 1'b1;
          tot_d  = '0;
          clip_d = 1'b0;
          wr_d   = '0;
          site_d = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      tot_q   <= '0;
      clip_q  <= 1'b0;
      wr_q    <= '0;
      site_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      tot_q   <= tot_d;
      clip_q  <= clip_d;
      wr_q    <= wr_d;
      site_q  <= site_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rho_q  <= rho_d;
    last_q <= last_d;
    len_q  <= len_d;
    rng_q  <= rng_d;
    cnt_q  <= cnt_d;
    n0_q   <= n0_d;
    y1_q   <= y1_d;
    y0_q   <= y0_d;
    x1_q   <= x1_d;
    x0_q   <= x0_d;
    job_q  <= job_d;
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    it_q   <= it_d;
    ln_q   <= ln_d;
    c_q    <= c_d;
    gp_q   <= gp_d;
    sat_q  <= sat_d;
  end

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = (state_q == ST_OUT);
  assign out_o.grand_potential = gp_q;
  assign out_o.saturated       = sat_q;

`ifndef ASSERT_OFF
  a_last_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && last_q) |=> out_o.valid)
    else $error("closing sample did not raise a result beat");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again while a sample is in work");
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (cnt_q <= len_q))
    else $error("window read count ran past the rod length");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a result beat waits");
`endif

endmodule
`default_nettype wire
